// ===== hdl/ap2h_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ap2h_pkg
// Shared types and constants for the absolute pointer to HID report block.
// ----------------------------------------------------------------------------
package ap2h_pkg;

  // field widths
  localparam int unsigned COORD_W = 16;
  localparam int unsigned MASK_W  = 8;
  localparam int unsigned BTN_W   = 3;
  localparam int unsigned WHEEL_W = 2;
  // a 16-bit coordinate times a scale factor of at most 2^16 stays below 2^32
  localparam int unsigned PROD_W  = 2 * COORD_W;
  // one quotient bit per divider stage
  localparam int unsigned NUM_STEPS = COORD_W;

  // stream widths
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 40;

  // register bus
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  // register index, taken from address bit 2
  localparam logic REG_SCREEN_WIDTH  = 1'b0;
  localparam logic REG_SCREEN_HEIGHT = 1'b1;

  // wheel codes
  localparam logic [WHEEL_W-1:0] WHEEL_NONE = 2'b00;
  localparam logic [WHEEL_W-1:0] WHEEL_UP   = 2'b01;
  localparam logic [WHEEL_W-1:0] WHEEL_DOWN = 2'b11;

  // screen geometry
  typedef struct packed {
    logic [COORD_W-1:0] width;
    logic [COORD_W-1:0] height;
  } cfg_t;

  // per-item flags that ride along the divider
  typedef struct packed {
    logic               accepted;
    logic [BTN_W-1:0]   buttons;
    logic [WHEEL_W-1:0] wheel;
  } side_t;

  // partial remainder and numerator bits, quotient bits shift in at the bottom
  typedef struct packed {
    logic [COORD_W-1:0] rem;
    logic [COORD_W-1:0] lo;
  } div_t;

  // one pipeline stage worth of payload
  typedef struct packed {
    side_t side;
    div_t  x;
    div_t  y;
  } stage_t;

endpackage

// ===== hdl/ap2h_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ap2h_regs
// Register bank for screen width and height behind a simple APB port.
// ----------------------------------------------------------------------------
module ap2h_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ap2h_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [ap2h_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [ap2h_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready,
  output ap2h_pkg::cfg_t                   cfg_o
);
  import ap2h_pkg::*;

  logic [COORD_W-1:0] width_q, width_d;
  logic [COORD_W-1:0] height_q, height_d;
  logic               wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // write decode
  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (wr_en) begin
      unique case (paddr[2])
        REG_SCREEN_WIDTH:  width_d  = pwdata[COORD_W-1:0];
        REG_SCREEN_HEIGHT: height_d = pwdata[COORD_W-1:0];
        default:           width_d  = width_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= '0;
      height_q <= '0;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  // read mux
  always_comb begin
    unique case (paddr[2])
      REG_SCREEN_WIDTH:  prdata = APB_DATA_W'(width_q);
      REG_SCREEN_HEIGHT: prdata = APB_DATA_W'(height_q);
      default:           prdata = '0;
    endcase
  end

  assign cfg_o.width  = width_q;
  assign cfg_o.height = height_q;

endmodule

// ===== hdl/ap2h_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ap2h_front
// First stage: bounds check, button and wheel remap, coordinate scaling.
// ----------------------------------------------------------------------------
module ap2h_front #(
  parameter int unsigned REPORT_MAX_X = 32767,
  parameter int unsigned REPORT_MAX_Y = 32767
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  ap2h_pkg::cfg_t                 cfg_i,
  input  logic                           valid_i,
  output logic                           ready_o,
  input  logic [ap2h_pkg::MASK_W-1:0]    button_mask_i,
  input  logic [ap2h_pkg::COORD_W-1:0]   pos_x_i,
  input  logic [ap2h_pkg::COORD_W-1:0]   pos_y_i,
  output logic                           valid_o,
  input  logic                           ready_i,
  output ap2h_pkg::stage_t               stage_o
);
  import ap2h_pkg::*;

  localparam int unsigned SCALE_W = COORD_W + 1;
  localparam logic [SCALE_W-1:0] SCALE_X = SCALE_W'(REPORT_MAX_X + 1);
  localparam logic [SCALE_W-1:0] SCALE_Y = SCALE_W'(REPORT_MAX_Y + 1);

  logic               valid_q;
  stage_t             stage_q, stage_d;
  logic               in_x, in_y;
  logic [PROD_W-1:0]  prod_x, prod_y;

  assign ready_o = !valid_q || ready_i;

  // bounds: strictly inside the screen, zero size rejects all
  assign in_x = (pos_x_i != '0) && (pos_x_i < cfg_i.width);
  assign in_y = (pos_y_i != '0) && (pos_y_i < cfg_i.height);

  // scale numerators
  assign prod_x = PROD_W'(pos_x_i) * PROD_W'(SCALE_X);
  assign prod_y = PROD_W'(pos_y_i) * PROD_W'(SCALE_Y);

  // button swap and wheel, upper part of the product seeds the remainder
  always_comb begin
    stage_d.side.accepted = in_x && in_y;
    stage_d.side.buttons  = {button_mask_i[1], button_mask_i[2], button_mask_i[0]};
    if (button_mask_i[3]) begin
      stage_d.side.wheel = WHEEL_UP;
    end else if (button_mask_i[4]) begin
      stage_d.side.wheel = WHEEL_DOWN;
    end else begin
      stage_d.side.wheel = WHEEL_NONE;
    end
    stage_d.x.rem = prod_x[2*COORD_W-1:COORD_W];
    stage_d.x.lo  = prod_x[COORD_W-1:0];
    stage_d.y.rem = prod_y[2*COORD_W-1:COORD_W];
    stage_d.y.lo  = prod_y[COORD_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

// ===== hdl/ap2h_div_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ap2h_div_step
// One restoring division step for both coordinates, one quotient bit each.
// ----------------------------------------------------------------------------
module ap2h_div_step (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ap2h_pkg::cfg_t    cfg_i,
  input  logic              valid_i,
  output logic              ready_o,
  input  ap2h_pkg::stage_t  stage_i,
  output logic              valid_o,
  input  logic              ready_i,
  output ap2h_pkg::stage_t  stage_o
);
  import ap2h_pkg::*;

  logic   valid_q;
  stage_t stage_q, stage_d;

  // shift in the next numerator bit, subtract when the divisor fits
  function automatic div_t step(input div_t cur, input logic [COORD_W-1:0] dvsr);
    logic [COORD_W:0] trial;
    logic             fits;
    div_t             nxt;
    trial   = {cur.rem, cur.lo[COORD_W-1]};
    fits    = trial >= {1'b0, dvsr};
    nxt.rem = fits ? COORD_W'(trial - {1'b0, dvsr}) : trial[COORD_W-1:0];
    nxt.lo  = {cur.lo[COORD_W-2:0], fits};
    return nxt;
  endfunction

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    stage_d.side = stage_i.side;
    stage_d.x    = step(stage_i.x, cfg_i.width);
    stage_d.y    = step(stage_i.y, cfg_i.height);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

// ===== hdl/abs_pointer_to_hid_report.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abs_pointer_to_hid_report
// Converts absolute pointer events into USB HID absolute-mouse report fields.
// ----------------------------------------------------------------------------
// Takes one pointer event per cycle while the output is not stalled and
// returns one report item per event. The pipeline is one stage for bounds
// check, button remap and scale multiply, then sixteen stages of a
// restoring divider, one quotient bit per stage, for x and y in parallel.
// Each stage stalls on its own, so bubbles are squeezed out and new events
// keep entering while a finished report waits. Screen size is read live by
// the divider stages: change it only while the block is empty.
// A rejected event comes out with accepted low and all report fields zero.
module abs_pointer_to_hid_report #(
  parameter int unsigned REPORT_MAX_X = 32767,
  parameter int unsigned REPORT_MAX_Y = 32767
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // register port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [ap2h_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [ap2h_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [ap2h_pkg::APB_DATA_W-1:0]    prdata,
  output logic                               pready,
  // event input
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [7:0] button_mask, [23:8] pos_x, [39:24] pos_y
  input  logic [ap2h_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // report output
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [0] accepted, [3:1] report_buttons, [19:4] report_x, [35:20] report_y,
  // [37:36] report_wheel, [39:38] zero
  output logic [ap2h_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
  import ap2h_pkg::*;

  cfg_t   cfg;
  stage_t stg [NUM_STEPS+1];
  logic   vld [NUM_STEPS+1];
  logic   rdy [NUM_STEPS+1];
  stage_t last;

  logic [BTN_W-1:0]   out_buttons;
  logic [COORD_W-1:0] out_x;
  logic [COORD_W-1:0] out_y;
  logic [WHEEL_W-1:0] out_wheel;

  // configuration registers
  ap2h_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // check, remap and scale
  ap2h_front #(
    .REPORT_MAX_X (REPORT_MAX_X),
    .REPORT_MAX_Y (REPORT_MAX_Y)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .valid_i       (s_axis_tvalid),
    .ready_o       (s_axis_tready),
    .button_mask_i (s_axis_tdata[MASK_W-1:0]),
    .pos_x_i       (s_axis_tdata[MASK_W+COORD_W-1:MASK_W]),
    .pos_y_i       (s_axis_tdata[MASK_W+2*COORD_W-1:MASK_W+COORD_W]),
    .valid_o       (vld[0]),
    .ready_i       (rdy[0]),
    .stage_o       (stg[0])
  );

  // divider pipeline
  for (genvar i = 0; i < NUM_STEPS; i++) begin : g_div
    ap2h_div_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cfg_i   (cfg),
      .valid_i (vld[i]),
      .ready_o (rdy[i]),
      .stage_i (stg[i]),
      .valid_o (vld[i+1]),
      .ready_i (rdy[i+1]),
      .stage_o (stg[i+1])
    );
  end

  assign last             = stg[NUM_STEPS];
  assign rdy[NUM_STEPS]   = m_axis_tready;
  assign m_axis_tvalid    = vld[NUM_STEPS];

  // rejected events report all zeros
  assign out_buttons = last.side.accepted ? last.side.buttons : '0;
  assign out_x       = last.side.accepted ? last.x.lo : '0;
  assign out_y       = last.side.accepted ? last.y.lo : '0;
  assign out_wheel   = last.side.accepted ? last.side.wheel : WHEEL_NONE;

  assign m_axis_tdata = {2'b00, out_wheel, out_y, out_x, out_buttons, last.side.accepted};

`ifndef SYNTHESIS
  // a rejected item carries no report
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[OUT_DATA_W-1:1] == '0)
    else $error("rejected item with nonzero report");

  // scaled coordinates never pass the report range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[0] |->
      (32'(m_axis_tdata[19:4]) <= REPORT_MAX_X) &&
      (32'(m_axis_tdata[35:20]) <= REPORT_MAX_Y))
    else $error("scaled coordinate out of range");

  // wheel is up, down or none
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[37:36] != 2'b10)
    else $error("bad wheel code");

  // input only stalls when the front stage is full and blocked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> vld[0] && !rdy[0])
    else $error("input stalled with room in the front stage");

  // an item leaving the last stage is gone unless another one moves in
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !vld[NUM_STEPS-1] |=> !m_axis_tvalid)
    else $error("output item repeated");
`endif

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the absolute pointer to HID report converter.
// ----------------------------------------------------------------------------
// Pointer events are queued by the sequence below and sent by a clocked
// driver. On acceptance each event is turned into its expected report by a
// local predictor that uses the bench's copy of the screen geometry. A clocked
// monitor pops one expectation per report and compares it field by field.
// The geometry is rewritten over the register port only while the block is
// empty. Source gaps and sink stalls are random and vary between phases.
// ----------------------------------------------------------------------------
module testbench;
  import ap2h_pkg::*;

  localparam int unsigned REPORT_MAX_X = 32767;
  localparam int unsigned REPORT_MAX_Y = 32767;
  localparam int unsigned STALL_LIMIT  = 5000;
  localparam int unsigned DRAIN_CYCLES = 40;

  // report fields, lowest bit last, laid out as on m_axis_tdata[37:0]
  typedef struct packed {
    logic [WHEEL_W-1:0] wheel;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
    logic [BTN_W-1:0]   buttons;
    logic               accepted;
  } hid_report_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // [7:0] button_mask, [23:8] pos_x, [39:24] pos_y
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // [0] accepted, [3:1] report_buttons, [19:4] report_x, [35:20] report_y,
  // [37:36] report_wheel, [39:38] zero
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  // bench copy of the geometry registers
  logic [COORD_W-1:0] geo_width = '0;
  logic [COORD_W-1:0] geo_height = '0;

  logic [IN_DATA_W-1:0] pending_events[$];
  hid_report_t          expected_reports[$];

  int src_idle_pct = 14;
  int dst_idle_pct = 77;
  int errors = 0;
  int unsigned stall_cycles = 0;

  abs_pointer_to_hid_report #(
    .REPORT_MAX_X (REPORT_MAX_X),
    .REPORT_MAX_Y (REPORT_MAX_Y)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // expected report for one event under the current geometry
  function automatic hid_report_t predict_report(input logic [IN_DATA_W-1:0] evt);
    logic [MASK_W-1:0]  mask;
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
    longint unsigned    num;
    hid_report_t        rep;
    mask = evt[7:0];
    px   = evt[23:8];
    py   = evt[39:24];
    rep  = '0;
    if (px != 0 && px < geo_width && py != 0 && py < geo_height) begin
      rep.accepted = 1'b1;
      // left stays, middle and right trade places
      rep.buttons  = {mask[1], mask[2], mask[0]};
      // wheel up wins over wheel down
      if (mask[3]) begin
        rep.wheel = WHEEL_UP;
      end else if (mask[4]) begin
        rep.wheel = WHEEL_DOWN;
      end else begin
        rep.wheel = WHEEL_NONE;
      end
      num   = longint'(px) * (longint'(REPORT_MAX_X) + 1);
      rep.x = COORD_W'(num / longint'(geo_width));
      num   = longint'(py) * (longint'(REPORT_MAX_Y) + 1);
      rep.y = COORD_W'(num / longint'(geo_height));
    end
    return rep;
  endfunction

  function automatic int field_ok(input string name, input longint unsigned want,
                                  input longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      return 0;
    end
    return 1;
  endfunction

  // event driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_reports.push_back(predict_report(s_axis_tdata));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_events.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          s_axis_tdata  <= pending_events.pop_front();
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // report monitor
  always @(posedge clk_i) begin : report_monitor
    hid_report_t got;
    hid_report_t want;
    int          ok;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = hid_report_t'(m_axis_tdata[37:0]);
        if (expected_reports.size() == 0) begin
          $error("report with no event pending: %h", m_axis_tdata);
          errors++;
        end else begin
          want = expected_reports.pop_front();
          ok = field_ok("accepted", want.accepted, got.accepted)
             & field_ok("report_buttons", want.buttons, got.buttons)
             & field_ok("report_x", want.x, got.x)
             & field_ok("report_y", want.y, got.y)
             & field_ok("report_wheel", want.wheel, got.wheel);
          if (ok == 0) begin
            errors++;
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= dst_idle_pct);
    end
  end

  // watchdog on cycles without progress while work is outstanding
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (pending_events.size() == 0 && expected_reports.size() == 0 &&
         !s_axis_tvalid)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // register write: setup cycle then access cycle
  task automatic write_reg(input logic ridx, input logic [COORD_W-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {ridx, 2'b00};
    pwdata  <= APB_DATA_W'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_geometry(input logic [COORD_W-1:0] w, input logic [COORD_W-1:0] h);
    write_reg(REG_SCREEN_WIDTH, w);
    geo_width = w;
    write_reg(REG_SCREEN_HEIGHT, h);
    geo_height = h;
  endtask

  // wait until every queued event is out and every report is back
  task automatic drain();
    do @(negedge clk_i);
    while (pending_events.size() != 0 || s_axis_tvalid || expected_reports.size() != 0);
  endtask

  task automatic add_event(input logic [7:0] mask, input logic [15:0] px,
                           input logic [15:0] py);
    pending_events.push_back({py, px, mask});
  endtask

  function automatic logic [15:0] edge_coord(input logic [15:0] size);
    case ($urandom_range(3))
      0: return 16'd0;
      1: return size;
      2: return 16'(size - 1'b1);
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  function automatic logic [15:0] inside_coord(input logic [15:0] size);
    if (size > 1) begin
      return 16'($urandom_range(int'(size) - 1, 1));
    end
    return edge_coord(size);
  endfunction

  // mostly on-screen events, the rest on the edges or anywhere
  task automatic add_random_events(input int count);
    int sel;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(9);
      case (sel)
        7: add_event(8'($urandom), inside_coord(geo_width), edge_coord(geo_height));
        8: add_event(8'($urandom), edge_coord(geo_width), inside_coord(geo_height));
        9: add_event(8'($urandom), 16'($urandom), 16'($urandom));
        default: add_event(8'($urandom), inside_coord(geo_width),
                           inside_coord(geo_height));
      endcase
    end
  endtask

  // sequence
  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // sender idles lightly, receiver stalls often
    src_idle_pct = 14;
    dst_idle_pct = 77;

    // zero geometry after reset rejects everything
    add_event(8'hFF, 16'd1, 16'd1);
    add_event(8'h01, 16'd100, 16'd100);
    add_event(8'h1F, 16'd65535, 16'd65535);
    add_random_events(20);
    drain();

    // each button and wheel bit, then the screen edges
    set_geometry(16'd1920, 16'd1080);
    add_event(8'h00, 16'd1, 16'd1);
    add_event(8'h01, 16'd1919, 16'd1079);
    add_event(8'h02, 16'd960, 16'd540);
    add_event(8'h04, 16'd960, 16'd540);
    add_event(8'h08, 16'd960, 16'd540);
    add_event(8'h10, 16'd960, 16'd540);
    add_event(8'h18, 16'd960, 16'd540);
    add_event(8'hE0, 16'd960, 16'd540);
    add_event(8'hFF, 16'd960, 16'd540);
    add_event(8'hFF, 16'd0, 16'd540);
    add_event(8'hFF, 16'd1920, 16'd540);
    add_event(8'hFF, 16'd960, 16'd0);
    add_event(8'hFF, 16'd960, 16'd1080);
    add_event(8'hFF, 16'd65535, 16'd540);
    add_event(8'hFF, 16'd960, 16'd65535);
    add_event(8'hFF, 16'd0, 16'd0);
    add_random_events(300);
    drain();

    // largest screen, scaled values near the top of the report range
    set_geometry(16'd65535, 16'd65535);
    add_event(8'h1F, 16'd65534, 16'd65534);
    add_event(8'h07, 16'd1, 16'd1);
    add_event(8'h00, 16'd32768, 16'd32767);
    add_random_events(300);
    drain();

    // receiver fast, sender sparse
    src_idle_pct = 77;
    dst_idle_pct = 14;

    // one-pixel screen has no inside position
    set_geometry(16'd1, 16'd1);
    add_random_events(50);
    drain();

    set_geometry(16'd2, 16'd65535);
    add_random_events(200);
    drain();

    set_geometry(16'd65535, 16'd2);
    add_random_events(200);
    drain();

    // no idling on either side
    src_idle_pct = 0;
    dst_idle_pct = 0;

    set_geometry(16'($urandom_range(65535, 2)), 16'($urandom_range(65535, 2)));
    add_random_events(400);
    drain();

    set_geometry(16'd0, 16'd1080);
    add_random_events(50);
    drain();

    set_geometry(16'd800, 16'd600);
    add_random_events(300);
    drain();

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_reports.size() != 0) begin
      $error("%0d reports never arrived", expected_reports.size());
      errors++;
    end
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
